[hdl/lbs_pkg.sv]
// Shared constants and helpers for the linear blend skinning core.
package lbs_pkg;
    localparam int unsigned BoneCount      = 256;
    localparam int unsigned Influences     = 4;
    localparam int unsigned PackedInfl     = 4;
    localparam int unsigned WordsPerBone   = 12;
    localparam int unsigned ElemW          = 4;
    localparam logic [15:0] WeightThresh   = 16'd3;
    localparam int unsigned ProdW          = 64;   // 32x32 signed product
    localparam int unsigned TermW          = 81;   // product times 16-bit weight
    localparam int unsigned AccW           = 88;   // sum of 16 terms plus margin

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_VERTEX  = 1'b1;

    // floor(acc / 2^31) saturated to signed 32 bits
    function automatic logic [31:0] sat_out(input logic signed [AccW-1:0] acc);
        logic signed [AccW-32:0] sh;
        sh = acc[AccW-1:31];
        if (!sh[AccW-32] && (sh[AccW-32:31] != '0)) begin
            sat_out = 32'h7FFF_FFFF;
        end else if (sh[AccW-32] && (sh[AccW-32:31] != '1)) begin
            sat_out = 32'h8000_0000;
        end else begin
            sat_out = sh[31:0];
        end
    endfunction
endpackage

[hdl/linear_blend_skinning_core.sv]
// Top level of the linear blend skinning core.
//   channel | dir | handshake        | payload
//   s_axis  | in  | tvalid/tready    | tdata: pos, indices, weights, palette; tuser: op; tlast
//   m_axis  | out | tvalid/tready    | tdata: skinned x,y,z; tlast: batch end
// One item per cycle while the output is not stalled; a vertex result is registered in order by
// the palette read at its accepting edge, then two multiplier stages, lane sum, influence sum
// and the output register.
// Palette loads write the per-influence banks and give no result.
// Synchronous active-low reset clears valid bits only; the palette is undefined until written.
// A stall freezes the whole pipeline; tready follows the output side directly.
module linear_blend_skinning_core #(
    parameter int unsigned BONE_COUNT = lbs_pkg::BoneCount,
    parameter int unsigned INFLUENCES = lbs_pkg::Influences
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: pos_x, pos_y, pos_z, bone_indices, bone_weights, palette_bone,
    //        palette_element, palette_value, zero pad (low bit first)
    input  logic [239:0] s_axis_tdata,
    input  logic         s_axis_tuser,  // operation
    input  logic         s_axis_tlast,  // last_vertex
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: skinned_x, skinned_y, skinned_z (low bit first)
    output logic [95:0]  m_axis_tdata,
    output logic         m_axis_tlast   // batch_end
);
    localparam int unsigned NL = (INFLUENCES < lbs_pkg::PackedInfl) ? INFLUENCES
                                                                    : lbs_pkg::PackedInfl;
    localparam int unsigned BW = $clog2(BONE_COUNT);
    localparam int unsigned CW = lbs_pkg::AccW;
    localparam int unsigned DEPTH = 5;

    logic        w_en;
    logic        w_acc;
    logic [31:0] w_px, w_py, w_pz, w_idx, w_val;
    logic [63:0] w_wts;
    logic [7:0]  w_pbone;
    logic [3:0]  w_pelem;
    logic        w_we;

    assign w_px    = s_axis_tdata[31:0];
    assign w_py    = s_axis_tdata[63:32];
    assign w_pz    = s_axis_tdata[95:64];
    assign w_idx   = s_axis_tdata[127:96];
    assign w_wts   = s_axis_tdata[191:128];
    assign w_pbone = s_axis_tdata[199:192];
    assign w_pelem = s_axis_tdata[203:200];
    assign w_val   = s_axis_tdata[235:204];

    logic r_out_v;
    assign w_en          = !r_out_v || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && w_en;
    assign w_we = w_acc && (s_axis_tuser == lbs_pkg::OP_PALETTE)
               && (32'(w_pbone) < BONE_COUNT) && (w_pelem < 4'(lbs_pkg::WordsPerBone));

    logic signed [CW-1:0] w_row [NL][3];

    for (genvar i = 0; i < NL; i++) begin : g_lane
        logic [7:0]  w_b;
        logic [15:0] w_w;
        logic        w_use;
        assign w_b   = w_idx[8*i +: 8];
        assign w_w   = w_wts[16*i +: 16];
        assign w_use = (w_w > lbs_pkg::WeightThresh) && (32'(w_b) < BONE_COUNT);
        lbs_lane #(.BONE_COUNT(BONE_COUNT)) u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_we    (w_we),
            .i_wbone (BW'(w_pbone)),
            .i_welem (w_pelem),
            .i_wdata (w_val),
            .i_bone  (BW'(w_b)),
            .i_use   (w_use),
            .i_weight(w_w),
            .i_px    (w_px),
            .i_py    (w_py),
            .i_pz    (w_pz),
            .o_row   (w_row[i])
        );
    end

    // valid and tlast travel alongside the lanes
    logic [DEPTH-1:0] r_v, n_v;
    logic [DEPTH-1:0] r_l;
    logic signed [CW-1:0] r_sum [3];
    logic signed [CW-1:0] n_sum [3];
    logic [95:0] r_out_d;
    logic        r_out_l;

    assign n_v = {r_v[DEPTH-2:0], w_acc && (s_axis_tuser == lbs_pkg::OP_VERTEX)};

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = '0;
            for (int i = 0; i < NL; i++) begin
                n_sum[r] = n_sum[r] + w_row[i][r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_v     <= n_v;
            r_out_v <= r_v[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l   <= {r_l[DEPTH-2:0], s_axis_tlast};
            r_sum <= n_sum;
            r_out_d <= {lbs_pkg::sat_out(r_sum[2]), lbs_pkg::sat_out(r_sum[1]),
                        lbs_pkg::sat_out(r_sum[0])};
            r_out_l <= r_l[DEPTH-1];
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_d;
    assign m_axis_tlast  = r_out_l;
endmodule

[hdl/lbs_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module lbs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/lbs_lane.sv]
// One influence lane: palette bank read, matrix-point products, weighting, row sums.
module lbs_lane #(
    parameter int unsigned BONE_COUNT = lbs_pkg::BoneCount
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic                              i_we,
    input  logic [$clog2(BONE_COUNT)-1:0]     i_wbone,
    input  logic [lbs_pkg::ElemW-1:0]         i_welem,
    input  logic [31:0]                       i_wdata,
    input  logic [$clog2(BONE_COUNT)-1:0]     i_bone,
    input  logic                              i_use,
    input  logic [15:0]                       i_weight,
    input  logic signed [31:0]                i_px,
    input  logic signed [31:0]                i_py,
    input  logic signed [31:0]                i_pz,
    // weighted row sums, three rows, each aligned to the accumulator
    output logic signed [lbs_pkg::AccW-1:0]   o_row [3]
);
    localparam int unsigned PW = lbs_pkg::ProdW;
    localparam int unsigned TW = lbs_pkg::TermW;
    localparam int unsigned CW = lbs_pkg::AccW;

    logic [31:0] w_word [12];

    // stage A: twelve banks, one per matrix word, read in parallel
    for (genvar e = 0; e < 12; e++) begin : g_bank
        logic w_we;
        assign w_we = i_we && (i_welem == lbs_pkg::ElemW'(e));
        lbs_ram #(.WIDTH(32), .DEPTH(BONE_COUNT)) u_bank (
            .i_clk  (i_clk),
            .i_we   (w_we),
            .i_waddr(i_wbone),
            .i_wdata(i_wdata),
            .i_re   (i_en),
            .i_raddr(i_bone),
            .o_rdata(w_word[e])
        );
    end

    // registers aligned with the RAM read
    logic               r_use_a;
    logic [15:0]        r_w_a, r_w_b;
    logic signed [31:0] r_p_a [3];
    logic signed [PW-1:0] r_prod_b [12];
    logic signed [TW-1:0] r_term_c [12];
    logic signed [CW-1:0] r_row_d [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_use_a  <= i_use;
            r_w_a    <= i_use ? i_weight : 16'd0;
            r_p_a[0] <= i_px;
            r_p_a[1] <= i_py;
            r_p_a[2] <= i_pz;
            // stage B: matrix times point, a 32x32 product per rotation word, translation word shifted left by 16
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod_b[r*4+c] <= $signed(w_word[r*4+c]) * r_p_a[c];
                end
                r_prod_b[r*4+3] <= PW'($signed(w_word[r*4+3])) <<< 16;
            end
            r_w_b <= r_use_a ? r_w_a : 16'd0;
            // stage C: weight each term
            for (int k = 0; k < 12; k++) begin
                r_term_c[k] <= r_prod_b[k] * $signed({1'b0, r_w_b});
            end
            // stage D: row sums
            for (int r = 0; r < 3; r++) begin
                r_row_d[r] <= CW'(r_term_c[r*4]) + CW'(r_term_c[r*4+1])
                            + CW'(r_term_c[r*4+2]) + CW'(r_term_c[r*4+3]);
            end
        end
    end

    assign o_row = r_row_d;
endmodule

[tb/tb.sv]
// Testbench for the linear blend skinning core: palette loads and vertex skinning.
`timescale 1ns / 100ps

module tb;
    localparam int unsigned TdataW   = 240;
    localparam int          FastFrom = 800;
    localparam int          FastTo   = 1100;

    typedef struct {
        logic               op;
        logic [TdataW-1:0]  data;
        logic               last;
    } t_stream_item;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } t_skinned_pos;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TdataW-1:0]  s_axis_tdata = '0;
    logic               s_axis_tuser = lbs_pkg::OP_PALETTE;
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [95:0]        m_axis_tdata;
    logic               m_axis_tlast;

    linear_blend_skinning_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_stream_item  pending_items[$];
    t_skinned_pos  expected_pos[$];
    logic [31:0]   bone_words[lbs_pkg::BoneCount*lbs_pkg::WordsPerBone];
    logic [11:0]   gen_written[lbs_pkg::BoneCount];
    int            full_bones[$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            hold_cycles = 0;
    int            vertices_sent = 0;
    int            loads_sent = 0;
    int            results_seen = 0;
    bit            in_taken = 0;
    bit            hold_fired = 0;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic t_stream_item pack_item(
        input logic op, input logic [31:0] px, input logic [31:0] py,
        input logic [31:0] pz, input logic [31:0] idx, input logic [63:0] wts,
        input logic lastv, input logic [7:0] bone, input logic [3:0] elem,
        input logic [31:0] val);
        t_stream_item it;
        it.op   = op;
        it.last = lastv;
        it.data = '0;
        it.data[235:0] = {val, elem, bone, wts, idx, pz, py, px};
        return it;
    endfunction

    function automatic logic [31:0] rand32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 262144)) - 131072);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return 16'($urandom_range(0, 5));
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    // Track which words each bone has at generation time; stimulus order matches DUT order.
    task automatic add_load(input int bone, input int elem, input logic [31:0] val);
        pending_items.push_back(pack_item(lbs_pkg::OP_PALETTE, $urandom(), $urandom(),
            $urandom(), $urandom(), {$urandom(), $urandom()}, 1'($urandom()), 8'(bone),
            4'(elem), val));
        if (elem < lbs_pkg::WordsPerBone) begin
            if (gen_written[bone] != 12'hFFF) begin
                gen_written[bone][elem] = 1'b1;
                if (gen_written[bone] == 12'hFFF) full_bones.push_back(bone);
            end
            loads_sent++;
        end
    endtask

    task automatic load_bone(input int bone);
        for (int e = 0; e < lbs_pkg::WordsPerBone; e++) add_load(bone, e, rand32());
    endtask

    task automatic add_vertex(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic [63:0] wts,
                              input logic lastv);
        logic [31:0] idx;
        for (int i = 0; i < 4; i++)
            idx[8*i +: 8] = 8'(full_bones[$urandom_range(0, full_bones.size() - 1)]);
        pending_items.push_back(pack_item(lbs_pkg::OP_VERTEX, px, py, pz, idx, wts, lastv,
            8'($urandom()), 4'($urandom()), $urandom()));
        vertices_sent++;
    endtask

    // Exact wide sum of weight * (M * p), floored by 2^31 and saturated.
    function automatic t_skinned_pos skin_vertex(input logic [TdataW-1:0] d,
                                                 input logic lastv);
        t_skinned_pos res;
        logic signed [31:0]  pos[3];
        logic signed [31:0]  mw;
        logic signed [63:0]  prod;
        logic signed [127:0] acc, term, wgt, sh;
        logic [15:0]         w;
        int                  bone;
        for (int c = 0; c < 3; c++) pos[c] = d[32*c +: 32];
        for (int r = 0; r < 3; r++) begin
            acc = '0;
            for (int i = 0; i < lbs_pkg::PackedInfl && i < lbs_pkg::Influences; i++) begin
                w    = d[128 + 16*i +: 16];
                bone = d[96 + 8*i +: 8];
                if (w <= lbs_pkg::WeightThresh || bone >= lbs_pkg::BoneCount) continue;
                wgt = {112'b0, w};
                for (int c = 0; c < 4; c++) begin
                    mw = bone_words[bone*lbs_pkg::WordsPerBone + r*4 + c];
                    if (c < 3) begin
                        prod = mw * pos[c];
                    end else begin
                        prod = mw;
                        prod = prod <<< 16;
                    end
                    term = prod;
                    acc  = acc + term * wgt;
                end
            end
            sh = acc >>> 31;
            if (sh > 128'sh7FFF_FFFF) sh = 128'sh7FFF_FFFF;
            else if (sh < -128'sh8000_0000) sh = -128'sh8000_0000;
            case (r)
                0: res.x = sh[31:0];
                1: res.y = sh[31:0];
                default: res.z = sh[31:0];
            endcase
        end
        res.last = lastv;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch %s got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Driver: present the next transaction at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pending_items.size() != 0 &&
                ((cycle_count > FastFrom && cycle_count < FastTo) ||
                 $urandom_range(0, 99) >= 23)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_items[0].op;
                s_axis_tdata  <= pending_items[0].data;
                s_axis_tlast  <= pending_items[0].last;
                void'(pending_items.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the core up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_fired && vertices_sent > 0 && results_seen == 200) begin
            hold_fired    <= 1'b1;
            hold_cycles   <= 300;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (cycle_count > FastFrom && cycle_count < FastTo) ||
                             ($urandom_range(0, 99) >= 23);
        end
    end

    // Monitor: update the model on input transactions, check output transactions.
    always @(posedge i_clk) begin
        t_skinned_pos want;
        int           bone, elem;
        cycle_count <= cycle_count + 1;
        in_taken    <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser == lbs_pkg::OP_PALETTE) begin
                bone = s_axis_tdata[199:192];
                elem = s_axis_tdata[203:200];
                if (bone < lbs_pkg::BoneCount && elem < lbs_pkg::WordsPerBone)
                    bone_words[bone*lbs_pkg::WordsPerBone + elem] = s_axis_tdata[235:204];
            end else begin
                expected_pos.push_back(skin_vertex(s_axis_tdata, s_axis_tlast));
            end
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen <= results_seen + 1;
            if (expected_pos.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = expected_pos.pop_front();
                if (m_axis_tdata[31:0] !== want.x)
                    report_mismatch("x", m_axis_tdata[31:0], want.x);
                if (m_axis_tdata[63:32] !== want.y)
                    report_mismatch("y", m_axis_tdata[63:32], want.y);
                if (m_axis_tdata[95:64] !== want.z)
                    report_mismatch("z", m_axis_tdata[95:64], want.z);
                if (m_axis_tlast !== want.last)
                    report_mismatch("batch_end", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    initial begin
        int kind;
        for (int b = 0; b < lbs_pkg::BoneCount; b++) gen_written[b] = '0;

        // Directed: identity bone, extreme bones, bone 255, ignored loads.
        for (int e = 0; e < lbs_pkg::WordsPerBone; e++)
            add_load(0, e, (e % 5 == 0) ? 32'h0001_0000 : 32'h0);
        for (int e = 0; e < lbs_pkg::WordsPerBone; e++) add_load(1, e, 32'h7FFF_FFFF);
        for (int e = 0; e < lbs_pkg::WordsPerBone; e++) add_load(255, e, 32'h8000_0000);
        add_load(2, 12, 32'hDEAD_BEEF);
        add_load(2, 15, 32'h1234_5678);
        add_vertex(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 64'h0000_0000_0000_8000, 1'b0);
        add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 64'h0003_0004_0003_0004, 1'b0);
        add_vertex(32'h1234_5678, 32'h0, 32'h0, 64'h0000_0003_0002_0001, 1'b1);
        add_vertex(32'h0, 32'h0, 32'h0, 64'h0, 1'b0);

        repeat (600) begin
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                load_bone($urandom_range(0, 255));
            end else if (kind < 20) begin
                add_load(full_bones[$urandom_range(0, full_bones.size() - 1)],
                         $urandom_range(0, 11), rand32());
            end else if (kind < 24) begin
                add_load($urandom_range(0, 255), $urandom_range(12, 15), $urandom());
            end else begin
                add_vertex(rand32(), rand32(), rand32(),
                           {rand_weight(), rand_weight(), rand_weight(), rand_weight()},
                           ($urandom_range(0, 7) == 0));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_pos.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("tb: %0d vertices skinned, %0d palette words loaded, %0d results checked",
                 vertices_sent, loads_sent, results_seen);
        $display("tb: covered extreme positions and weights, saturation, ignored loads, stalls");
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("tb: timeout");
        $display("tb: done, errors");
        $finish;
    end
endmodule

[filelist.f]
hdl/lbs_pkg.sv
hdl/lbs_ram.sv
hdl/lbs_lane.sv
hdl/linear_blend_skinning_core.sv
tb/tb.sv
